@@ src/xsr_pkg.sv @@
// Shared constants and types for the xoshiro256** generator.
package xsr_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int NUM_WORDS = 4;

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D049BB133111EB;

    localparam logic [WORD_W-1:0] INIT_WORD0 = 64'h9ABCDEF012345678;
    localparam logic [WORD_W-1:0] INIT_WORD1 = 64'h1234567890ABCDEF;
    localparam logic [WORD_W-1:0] INIT_WORD2 = 64'hFEDCBA9876543210;
    localparam logic [WORD_W-1:0] INIT_WORD3 = 64'hABCDEF0123456789;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    localparam logic [1:0] MUL_STEP_LAST = 2'd2;
    localparam logic [1:0] WORD_IDX_LAST = 2'd3;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DRAW_OUT = 6'b000010,
        ST_RS_ADD   = 6'b000100,
        ST_RS_XOR   = 6'b001000,
        ST_RS_MUL   = 6'b010000,
        ST_RS_STORE = 6'b100000
    } xsr_state_t;

endpackage

@@ src/xoshiro256ss_random_generator.sv @@
// Top level of the xoshiro256** generator with SplitMix64 reseeding.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  s_cmd, s_seed_value
//   m_        out        m_valid / m_ready  m_random_word
//
// A draw advances the state and registers the scrambler's first half on
// acceptance, and the output register loads in ST_DRAW_OUT once it is free.
// A reseed runs four SplitMix64 rounds after acceptance, each an add, then an
// xor and a multiply twice, then a store, where each 64-bit constant multiply
// runs as three passes through one 32x32 multiplier.
// Reset is synchronous and active low; it loads the four fixed state words.
// A waiting result holds the draw in its final cycle until m_ready frees the
// output register.
module xoshiro256ss_random_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic [xsr_pkg::WORD_W-1:0]  s_seed_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [xsr_pkg::WORD_W-1:0]  m_random_word
);
    import xsr_pkg::*;

    xsr_state_t state_reg, state_next;

    logic [WORD_W-1:0] gen_word_reg  [NUM_WORDS];
    logic [WORD_W-1:0] gen_word_next [NUM_WORDS];

    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] z_reg, z_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] out_reg, out_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        mul_step_reg, mul_step_next;
    logic              mix_sel_reg, mix_sel_next;
    logic [1:0]        word_idx_reg, word_idx_next;

    logic [WORD_W-1:0] w1_times5;
    logic [WORD_W-1:0] w2_x, w3_x, w1_x, w0_x;
    logic [WORD_W-1:0] mix_const;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [WORD_W-1:0] mul_p;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_random_word = out_reg;

    assign w1_times5 = gen_word_reg[1] + {gen_word_reg[1][WORD_W-3:0], 2'b00};
    assign w2_x      = gen_word_reg[2] ^ gen_word_reg[0];
    assign w3_x      = gen_word_reg[3] ^ gen_word_reg[1];
    assign w1_x      = gen_word_reg[1] ^ w2_x;
    assign w0_x      = gen_word_reg[0] ^ w3_x;

    // The low 64 bits of the product are built from three 32x32 partial products.
    assign mix_const = mix_sel_reg ? MIX_MUL_B : MIX_MUL_A;
    assign mul_a     = (mul_step_reg == 2'd1) ? z_reg[WORD_W-1:HALF_W] : z_reg[HALF_W-1:0];
    assign mul_b     = (mul_step_reg == MUL_STEP_LAST) ? mix_const[WORD_W-1:HALF_W]
                                                       : mix_const[HALF_W-1:0];
    assign mul_p     = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

    always_comb begin
        state_next    = state_reg;
        gen_word_next = gen_word_reg;
        acc_next      = acc_reg;
        z_next        = z_reg;
        prod_next     = prod_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mul_step_next = mul_step_reg;
        mix_sel_next  = mix_sel_reg;
        word_idx_next = word_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_RESEED) begin
                        acc_next      = s_seed_value;
                        word_idx_next = 2'd0;
                        mix_sel_next  = 1'b0;
                        state_next    = ST_RS_ADD;
                    end else begin
                        z_next           = {w1_times5[WORD_W-8:0], w1_times5[WORD_W-1:WORD_W-7]};
                        gen_word_next[0] = w0_x;
                        gen_word_next[1] = w1_x;
                        gen_word_next[2] = w2_x ^ {gen_word_reg[1][WORD_W-18:0], 17'b0};
                        gen_word_next[3] = {w3_x[18:0], w3_x[WORD_W-1:19]};
                        state_next       = ST_DRAW_OUT;
                    end
                end
            end
            ST_DRAW_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = z_reg + {z_reg[WORD_W-4:0], 3'b000};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RS_ADD: begin
                acc_next   = acc_reg + GOLDEN_GAMMA;
                state_next = ST_RS_XOR;
            end
            ST_RS_XOR: begin
                if (mix_sel_reg) begin
                    z_next = prod_reg ^ {27'b0, prod_reg[WORD_W-1:27]};
                end else begin
                    z_next = acc_reg ^ {30'b0, acc_reg[WORD_W-1:30]};
                end
                mul_step_next = 2'd0;
                state_next    = ST_RS_MUL;
            end
            ST_RS_MUL: begin
                if (mul_step_reg == 2'd0) begin
                    prod_next = mul_p;
                end else begin
                    prod_next[WORD_W-1:HALF_W] = prod_reg[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];
                end
                if (mul_step_reg == MUL_STEP_LAST) begin
                    mul_step_next = 2'd0;
                    if (mix_sel_reg) begin
                        state_next = ST_RS_STORE;
                    end else begin
                        mix_sel_next = 1'b1;
                        state_next   = ST_RS_XOR;
                    end
                end else begin
                    mul_step_next = mul_step_reg + 2'd1;
                end
            end
            ST_RS_STORE: begin
                gen_word_next[word_idx_reg] = prod_reg ^ {31'b0, prod_reg[WORD_W-1:31]};
                mix_sel_next = 1'b0;
                if (word_idx_reg == WORD_IDX_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    word_idx_next = word_idx_reg + 2'd1;
                    state_next    = ST_RS_ADD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            mul_step_reg    <= 2'd0;
            mix_sel_reg     <= 1'b0;
            word_idx_reg    <= 2'd0;
            gen_word_reg[0] <= INIT_WORD0;
            gen_word_reg[1] <= INIT_WORD1;
            gen_word_reg[2] <= INIT_WORD2;
            gen_word_reg[3] <= INIT_WORD3;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            mul_step_reg <= mul_step_next;
            mix_sel_reg  <= mix_sel_next;
            word_idx_reg <= word_idx_next;
            gen_word_reg <= gen_word_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        z_reg    <= z_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

endmodule

@@ src/xsr_checker.sv @@
// Port-level checker for the xoshiro256** generator and its bind statement.
module xsr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_cmd,
    input logic [xsr_pkg::WORD_W-1:0]  s_seed_value,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [xsr_pkg::WORD_W-1:0]  m_random_word
);
    import xsr_pkg::*;

    logic in_xact;
    assign in_xact = s_valid && s_ready;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid is set after reset.");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_word))
        else $error("Stalled result transaction changed.");

    a_busy_after_xact: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xact |=> !s_ready)
        else $error("Input accepted in the cycle after a transaction.");

    a_reseed_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xact && (s_cmd == CMD_RESEED) && !m_valid |=> !m_valid)
        else $error("Reseed transaction produced a result.");

    a_draw_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xact && (s_cmd == CMD_DRAW) && !m_valid |=> ##1 m_valid)
        else $error("Draw transaction gave no result in time.");

endmodule

bind xoshiro256ss_random_generator xsr_checker u_xsr_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for the xoshiro256** generator with SplitMix64 reseeding.
`timescale 1ns / 1ps

module testbench;
    import xsr_pkg::*;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] seed;
        logic              known;
        logic [WORD_W-1:0] word;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 20;
    localparam int RANDOM_ITEMS = 1530;
    localparam int PHASE_ITEMS = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 100;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{CMD_DRAW,   64'h0000000000000000, 1'b1, 64'h999998B719998315},
        '{CMD_DRAW,   64'h0000000000000000, 1'b0, 64'h0},
        '{CMD_DRAW,   64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
        '{CMD_RESEED, 64'h0000000000000000, 1'b0, 64'h0},
        '{CMD_DRAW,   64'h0000000000000000, 1'b0, 64'h0},
        '{CMD_DRAW,   64'h0000000000000000, 1'b0, 64'h0},
        '{CMD_RESEED, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
        '{CMD_DRAW,   64'h0000000000000000, 1'b0, 64'h0},
        '{CMD_DRAW,   64'h0000000000000000, 1'b0, 64'h0},
        '{CMD_RESEED, 64'h8000000000000000, 1'b0, 64'h0},
        '{CMD_DRAW,   64'h0000000000000000, 1'b0, 64'h0},
        '{CMD_RESEED, 64'h0000000000000001, 1'b0, 64'h0},
        '{CMD_RESEED, 64'hAAAAAAAAAAAAAAAA, 1'b0, 64'h0},
        '{CMD_DRAW,   64'h0000000000000000, 1'b0, 64'h0},
        '{CMD_DRAW,   64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
        '{CMD_RESEED, 64'h5555555555555555, 1'b0, 64'h0},
        '{CMD_DRAW,   64'h0000000000000000, 1'b0, 64'h0},
        // This seed cancels the first golden-gamma step, so the first word is zero.
        '{CMD_RESEED, 64'h61C8864680B583EB, 1'b0, 64'h0},
        '{CMD_DRAW,   64'h0000000000000000, 1'b0, 64'h0},
        '{CMD_DRAW,   64'h0000000000000000, 1'b0, 64'h0}
    };

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_cmd = CMD_DRAW;
    logic [WORD_W-1:0] s_seed_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [WORD_W-1:0] m_random_word;

    logic [WORD_W-1:0] gen_state [NUM_WORDS];
    logic [WORD_W-1:0] pending_words [$];
    int                mismatch_count = 0;
    bit                tx_quiet = 1'b0;
    bit                rx_quiet = 1'b0;
    bit                long_hold_req = 1'b0;

    xoshiro256ss_random_generator uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_seed_value  (s_seed_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_word (m_random_word)
    );

    always #5 aclk = ~aclk;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    task automatic load_reset_state();
        gen_state[0] = INIT_WORD0;
        gen_state[1] = INIT_WORD1;
        gen_state[2] = INIT_WORD2;
        gen_state[3] = INIT_WORD3;
    endtask

    task automatic splitmix_reseed(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] z;
        acc = seed;
        for (int i = 0; i < NUM_WORDS; i++) begin
            acc = acc + GOLDEN_GAMMA;
            z = acc;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            gen_state[i] = z ^ (z >> 31);
        end
    endtask

    task automatic next_random_word(output logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] scaled;
        logic [WORD_W-1:0] carry;
        w1 = gen_state[1];
        scaled = w1 * 64'd5;
        word = rotl64(scaled, 7) * 64'd9;
        carry = w1 << 17;
        gen_state[2] = gen_state[2] ^ gen_state[0];
        gen_state[3] = gen_state[3] ^ gen_state[1];
        gen_state[1] = gen_state[1] ^ gen_state[2];
        gen_state[0] = gen_state[0] ^ gen_state[3];
        gen_state[2] = gen_state[2] ^ carry;
        gen_state[3] = rotl64(gen_state[3], 45);
    endtask

    // Offers one transaction and updates the predicted state once it is accepted.
    task automatic send_command(input logic cmd, input logic [WORD_W-1:0] seed,
                                input logic known, input logic [WORD_W-1:0] known_word);
        int                gap;
        logic [WORD_W-1:0] word;
        gap = tx_quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_seed_value <= seed;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_RESEED) begin
            splitmix_reseed(seed);
        end else begin
            next_random_word(word);
            pending_words.push_back(known ? known_word : word);
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(posedge aclk) begin : check_output
        logic [WORD_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("random_word: unexpected transaction with value %h", m_random_word);
                mismatch_count++;
            end else begin
                want = pending_words.pop_front();
                if (m_random_word !== want) begin
                    $error("random_word: expected %h, actual %h", want, m_random_word);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : receiver
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : driver
        int         sent;
        int         phase;
        logic       cmd;
        load_reset_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_command(DIRECTED[i].cmd, DIRECTED[i].seed, DIRECTED[i].known,
                         DIRECTED[i].word);
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                tx_quiet = 1'b1;
                long_hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS && sent < RANDOM_ITEMS; k++) begin
                cmd = ($urandom_range(0, 15) == 0) ? CMD_RESEED : CMD_DRAW;
                send_command(cmd, pick_seed(), 1'b0, '0);
                sent++;
            end
            if (phase % 4 == 2) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_words.size() != 0);
            end
            phase++;
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
